// ----- hw/rtl/vnbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector norm block statistics package
// Widths, register codes and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package vnbs_pkg;

   // Block depth is a power of two so that the floor average is an arithmetic shift.
   localparam int DEPTH_LOG2 = 4;
   localparam int DEPTH      = 1 << DEPTH_LOG2;
   localparam int POS_W      = DEPTH_LOG2;
   localparam int POS_OUT_W  = 8;

   localparam int SAMPLE_W   = 16;
   localparam int OFFSET_W   = 17;
   localparam int NORM_W     = 18;
   localparam int SQ_W       = 2 * SAMPLE_W;
   localparam int ROOT_W     = SQ_W / 2;
   localparam int REM_W      = ROOT_W + 2;
   localparam int NSUM_W     = NORM_W + DEPTH_LOG2;
   localparam int ASUM_W     = SAMPLE_W + DEPTH_LOG2;

   localparam int CNT_W      = $clog2(ROOT_W);
   localparam int SQ_LAST    = 2;
   localparam int ROOT_LAST  = ROOT_W - 1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [NORM_W-1:0] NORM_MAX = {1'b0, {(NORM_W-1){1'b1}}};
   localparam logic signed [NORM_W-1:0] NORM_MIN = {1'b1, {(NORM_W-1){1'b0}}};

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef enum logic {
      REG_MODE   = 1'b0,
      REG_OFFSET = 1'b1
   } reg_index_type;

   typedef enum logic {
      MODE_NORM = 1'b0,
      MODE_AXIS = 1'b1
   } mode_type;

   typedef struct packed {
      logic     capture;
      logic     square_step;
      axis_type axis_sel;
      logic     root_step;
      logic     fetch;
      logic     update;
      logic     load_out;
   } cmd_type;

endpackage

// ----- hw/rtl/vnbs_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector norm block statistics channels
// Valid/ready sample channel and result channel.
// ----------------------------------------------------------------------------
interface vnbs_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [vnbs_pkg::SAMPLE_W-1:0] sample_x;
   logic signed [vnbs_pkg::SAMPLE_W-1:0] sample_y;
   logic signed [vnbs_pkg::SAMPLE_W-1:0] sample_z;

   modport source (output valid, sample_x, sample_y, sample_z, input ready);
   modport sink   (input valid, sample_x, sample_y, sample_z, output ready);
endinterface

interface vnbs_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [vnbs_pkg::NORM_W-1:0]    avg_norm;
   logic signed [vnbs_pkg::NORM_W-1:0]    min_norm;
   logic signed [vnbs_pkg::NORM_W-1:0]    max_norm;
   logic signed [vnbs_pkg::SAMPLE_W-1:0]  avg_x;
   logic signed [vnbs_pkg::SAMPLE_W-1:0]  avg_y;
   logic signed [vnbs_pkg::SAMPLE_W-1:0]  avg_z;
   logic        [vnbs_pkg::POS_OUT_W-1:0] position;

   modport source (output valid, avg_norm, min_norm, max_norm, avg_x, avg_y, avg_z,
                   position, input ready);
   modport sink   (input valid, avg_norm, min_norm, max_norm, avg_x, avg_y, avg_z,
                   position, output ready);
endinterface

// ----- hw/rtl/vector_norm_block_statistics_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector norm block statistics core
// Magnitude min/max/block average or per-axis block averages of 3-axis samples.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one three-axis sample per transaction; rsp returns exactly one
//   result per sample with the latched block averages, the running minimum and
//   maximum of the offset magnitude, and the block position after the sample.
//   The mode and norm_offset registers sit on the APB-style port at byte
//   addresses 0 and 4; write them only while no sample is in flight.
//   Sequence: in magnitude mode an accepted sample is squared axis by axis on
//   one shared multiplier, passed through the bit-serial square root, then goes
//   through fetch, ring update and load. Axis mode skips the squarer and root
//   and goes straight to fetch, ring update and load. One sample is worked on
//   at a time and the next is accepted the cycle after the load, so the core
//   does not take a new sample before the last one has been loaded.
//   Reset clears the rings, running sums, position and averages to zero and
//   sets the minimum and maximum to their extreme values; no clearing pass is
//   needed. A stalled result waits in the output register; the block still
//   accepts and computes the next sample and holds it until the slot frees.
// ----------------------------------------------------------------------------
module vector_norm_block_statistics_core (
   input  logic                                clock,
   input  logic                                reset,
   vnbs_req_if.sink                            req,
   vnbs_rsp_if.source                          rsp,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [vnbs_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [vnbs_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [vnbs_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import vnbs_pkg::*;

   mode_type                   mode;
   logic signed [OFFSET_W-1:0] norm_offset;
   cmd_type                    cmd;

   vnbs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .mode        (mode),
      .norm_offset (norm_offset)
   );

   vnbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   vnbs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .mode        (mode),
      .norm_offset (norm_offset),
      .sample_x    (req.sample_x),
      .sample_y    (req.sample_y),
      .sample_z    (req.sample_z),
      .avg_norm    (rsp.avg_norm),
      .min_norm    (rsp.min_norm),
      .max_norm    (rsp.max_norm),
      .avg_x       (rsp.avg_x),
      .avg_y       (rsp.avg_y),
      .avg_z       (rsp.avg_z),
      .position    (rsp.position)
   );

endmodule

// ----- hw/rtl/vnbs_csr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector norm block statistics register file
// APB-style mode and magnitude offset registers.
// ----------------------------------------------------------------------------
module vnbs_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [vnbs_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [vnbs_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [vnbs_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready,
   output vnbs_pkg::mode_type                    mode,
   output logic signed [vnbs_pkg::OFFSET_W-1:0] norm_offset
);
   import vnbs_pkg::*;

   mode_type                   mode_ff, mode_in;
   logic signed [OFFSET_W-1:0] offset_ff, offset_in;
   reg_index_type              index;
   logic                       wr_en;

   assign index  = reg_index_type'(paddr[2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      mode_in   = mode_ff;
      offset_in = offset_ff;
      if (wr_en) begin
         unique case (index)
            REG_MODE:   mode_in   = mode_type'(pwdata[0]);
            REG_OFFSET: offset_in = $signed(pwdata[OFFSET_W-1:0]);
            default:    mode_in   = mode_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_MODE:   prdata = CSR_DATA_W'(mode_ff);
         REG_OFFSET: prdata = CSR_DATA_W'(offset_ff);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NORM;
         offset_ff <= '0;
      end else begin
         mode_ff   <= mode_in;
         offset_ff <= offset_in;
      end
   end

   assign mode        = mode_ff;
   assign norm_offset = offset_ff;

endmodule

// ----- hw/rtl/vnbs_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector norm block statistics controller
// Sequences squaring, bit-serial root, ring update and result hand-off.
// ----------------------------------------------------------------------------
module vnbs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  vnbs_pkg::mode_type mode,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output vnbs_pkg::cmd_type  cmd
);
   import vnbs_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SQUARE = 6'b000010,
      ST_ROOT   = 6'b000100,
      ST_FETCH  = 6'b001000,
      ST_UPDATE = 6'b010000,
      ST_LOAD   = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             valid_ff, valid_in;
   logic             req_fire;
   logic             out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !valid_ff || rsp_ready;

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      cmd             = '0;
      cmd.axis_sel    = axis_type'(cnt_ff[1:0]);
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_fire) begin
               cmd.capture = 1'b1;
               state_in    = (mode == MODE_AXIS) ? ST_FETCH : ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square_step = 1'b1;
            if (cnt_ff == CNT_W'(SQ_LAST)) begin
               cnt_in   = '0;
               state_in = ST_ROOT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ROOT_LAST)) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

`ifndef ASSERT_OFF
   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(valid_ff) |-> $past(state_ff == ST_LOAD))
      else $error("result valid rose without a load");

   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_SQUARE || state_ff == ST_FETCH))
      else $error("accepted transaction did not start work");

   a_root_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT && $past(state_ff) != ST_ROOT) |-> cnt_ff == '0)
      else $error("root iteration count not cleared");

   a_update_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE |=> state_ff == ST_LOAD)
      else $error("ring update not followed by load");
`endif

endmodule

// ----- hw/rtl/vnbs_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector norm block statistics datapath
// Squarer, bit-serial root, rings with running sums, min/max and result regs.
// ----------------------------------------------------------------------------
module vnbs_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  vnbs_pkg::cmd_type                      cmd,
   input  vnbs_pkg::mode_type                     mode,
   input  logic signed [vnbs_pkg::OFFSET_W-1:0]  norm_offset,
   input  logic signed [vnbs_pkg::SAMPLE_W-1:0]  sample_x,
   input  logic signed [vnbs_pkg::SAMPLE_W-1:0]  sample_y,
   input  logic signed [vnbs_pkg::SAMPLE_W-1:0]  sample_z,
   output logic signed [vnbs_pkg::NORM_W-1:0]    avg_norm,
   output logic signed [vnbs_pkg::NORM_W-1:0]    min_norm,
   output logic signed [vnbs_pkg::NORM_W-1:0]    max_norm,
   output logic signed [vnbs_pkg::SAMPLE_W-1:0]  avg_x,
   output logic signed [vnbs_pkg::SAMPLE_W-1:0]  avg_y,
   output logic signed [vnbs_pkg::SAMPLE_W-1:0]  avg_z,
   output logic        [vnbs_pkg::POS_OUT_W-1:0] position
);
   import vnbs_pkg::*;

   logic signed [SAMPLE_W-1:0] x_ff, y_ff, z_ff;
   logic        [SQ_W-1:0]     acc_ff, acc_in;
   logic        [REM_W-1:0]    rem_ff, rem_in;
   logic        [ROOT_W-1:0]   root_ff, root_in;
   logic signed [SAMPLE_W-1:0] sq_operand;
   logic signed [SQ_W-1:0]     sq_product;
   logic        [REM_W+1:0]    rem_shift;
   logic        [REM_W+1:0]    trial;

   logic signed [NORM_W-1:0]   mag_ff;
   logic signed [NORM_W-1:0]   old_norm_ff;
   logic signed [SAMPLE_W-1:0] old_x_ff, old_y_ff, old_z_ff;

   logic        [POS_W-1:0]    pos_ff;
   logic signed [NORM_W-1:0]   norm_store_ff [DEPTH];
   logic signed [SAMPLE_W-1:0] x_store_ff [DEPTH];
   logic signed [SAMPLE_W-1:0] y_store_ff [DEPTH];
   logic signed [SAMPLE_W-1:0] z_store_ff [DEPTH];
   logic signed [NSUM_W-1:0]   sum_norm_ff;
   logic signed [ASUM_W-1:0]   sum_x_ff, sum_y_ff, sum_z_ff;
   logic signed [NORM_W-1:0]   lat_norm_ff, min_ff, max_ff;
   logic signed [SAMPLE_W-1:0] lat_x_ff, lat_y_ff, lat_z_ff;
   logic                       block_start;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff <= sample_x;
         y_ff <= sample_y;
         z_ff <= sample_z;
      end
   end

   // One shared squarer, one axis per cycle into the accumulator.
   always_comb begin
      unique case (cmd.axis_sel)
         AXIS_X:  sq_operand = x_ff;
         AXIS_Y:  sq_operand = y_ff;
         AXIS_Z:  sq_operand = z_ff;
         default: sq_operand = x_ff;
      endcase
   end

   assign sq_product = sq_operand * sq_operand;

   // Restoring square root, two radicand bits per step; the radicand is
   // shifted out of the accumulator from the top.
   assign rem_shift = {rem_ff, acc_ff[SQ_W-1 -: 2]};
   assign trial     = {2'b00, root_ff, 2'b01};

   always_comb begin
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (cmd.capture) begin
         acc_in  = '0;
         rem_in  = '0;
         root_in = '0;
      end else if (cmd.square_step) begin
         acc_in = acc_ff + SQ_W'(unsigned'(sq_product));
      end else if (cmd.root_step) begin
         acc_in = acc_ff << 2;
         if (rem_shift >= trial) begin
            rem_in  = REM_W'(rem_shift - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(rem_shift);
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         mag_ff      <= $signed({{(NORM_W-ROOT_W){1'b0}}, root_ff}) + NORM_W'(norm_offset);
         old_norm_ff <= norm_store_ff[pos_ff];
         old_x_ff    <= x_store_ff[pos_ff];
         old_y_ff    <= y_store_ff[pos_ff];
         old_z_ff    <= z_store_ff[pos_ff];
      end
   end

   assign block_start = (pos_ff == '0);

   // Running sums track each ring, so the average at a block start is a shift
   // of the sum as it stands before the new entry replaces the oldest one.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         sum_norm_ff <= '0;
         sum_x_ff    <= '0;
         sum_y_ff    <= '0;
         sum_z_ff    <= '0;
         lat_norm_ff <= '0;
         lat_x_ff    <= '0;
         lat_y_ff    <= '0;
         lat_z_ff    <= '0;
         min_ff      <= NORM_MAX;
         max_ff      <= NORM_MIN;
         for (int i = 0; i < DEPTH; i++) begin
            norm_store_ff[i] <= '0;
            x_store_ff[i]    <= '0;
            y_store_ff[i]    <= '0;
            z_store_ff[i]    <= '0;
         end
      end else if (cmd.update) begin
         pos_ff <= pos_ff + 1'b1;
         if (mode == MODE_NORM) begin
            if (block_start) begin
               lat_norm_ff <= NORM_W'(sum_norm_ff >>> DEPTH_LOG2);
            end
            sum_norm_ff <= sum_norm_ff + NSUM_W'(mag_ff) - NSUM_W'(old_norm_ff);
            norm_store_ff[pos_ff] <= mag_ff;
            if (mag_ff < min_ff) begin
               min_ff <= mag_ff;
            end
            if (mag_ff > max_ff) begin
               max_ff <= mag_ff;
            end
         end else begin
            if (block_start) begin
               lat_x_ff <= SAMPLE_W'(sum_x_ff >>> DEPTH_LOG2);
               lat_y_ff <= SAMPLE_W'(sum_y_ff >>> DEPTH_LOG2);
               lat_z_ff <= SAMPLE_W'(sum_z_ff >>> DEPTH_LOG2);
            end
            sum_x_ff <= sum_x_ff + ASUM_W'(x_ff) - ASUM_W'(old_x_ff);
            sum_y_ff <= sum_y_ff + ASUM_W'(y_ff) - ASUM_W'(old_y_ff);
            sum_z_ff <= sum_z_ff + ASUM_W'(z_ff) - ASUM_W'(old_z_ff);
            x_store_ff[pos_ff] <= x_ff;
            y_store_ff[pos_ff] <= y_ff;
            z_store_ff[pos_ff] <= z_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         avg_norm <= lat_norm_ff;
         min_norm <= min_ff;
         max_norm <= max_ff;
         avg_x    <= lat_x_ff;
         avg_y    <= lat_y_ff;
         avg_z    <= lat_z_ff;
         position <= POS_OUT_W'(pos_ff);
      end
   end

endmodule

// ----- tb/sv/vector_norm_block_statistics_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector norm block statistics core testbench
// Drives three-axis samples through the core with random idling on both
// channels, reprograms mode and offset between phases, and compares every
// result against a cycle-free prediction of the block averages, the running
// minimum and maximum, and the block position.
// ----------------------------------------------------------------------------
import vnbs_pkg::*;

typedef struct {
   logic signed [NORM_W-1:0]   avg_norm;
   logic signed [NORM_W-1:0]   min_norm;
   logic signed [NORM_W-1:0]   max_norm;
   logic signed [SAMPLE_W-1:0] avg_x;
   logic signed [SAMPLE_W-1:0] avg_y;
   logic signed [SAMPLE_W-1:0] avg_z;
   logic [POS_OUT_W-1:0]       position;
} block_stats_result;

class block_stats_tracker;
   mode_type                   mode;
   logic signed [OFFSET_W-1:0] norm_offset;
   int unsigned                block_pos;
   longint                     mag_ring[DEPTH];
   longint                     x_ring[DEPTH];
   longint                     y_ring[DEPTH];
   longint                     z_ring[DEPTH];
   longint                     lowest;
   longint                     highest;
   longint                     avg_mag;
   longint                     avg_x;
   longint                     avg_y;
   longint                     avg_z;
   block_stats_result          due_results[$];
   int                         errors;

   function new();
      mode        = MODE_NORM;
      norm_offset = '0;
      block_pos   = 0;
      foreach (mag_ring[i]) begin
         mag_ring[i] = 0;
         x_ring[i]   = 0;
         y_ring[i]   = 0;
         z_ring[i]   = 0;
      end
      lowest  = NORM_MAX;
      highest = NORM_MIN;
      avg_mag = 0;
      avg_x   = 0;
      avg_y   = 0;
      avg_z   = 0;
      errors  = 0;
   endfunction

   function void set_register(reg_index_type index, logic [CSR_DATA_W-1:0] value);
      case (index)
         REG_MODE:   mode = mode_type'(value[0]);
         REG_OFFSET: norm_offset = value[OFFSET_W-1:0];
      endcase
   endfunction

   // Builds the root one bit at a time from the top; 17 bits cover sqrt(3 * 2^30).
   function longint floor_root(longint square);
      longint root;
      longint trial;
      root = 0;
      for (int b = 16; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= square) root = trial;
      end
      return root;
   endfunction

   function void note_sample(logic signed [SAMPLE_W-1:0] x, logic signed [SAMPLE_W-1:0] y,
                             logic signed [SAMPLE_W-1:0] z);
      longint            sum_m;
      longint            sum_x;
      longint            sum_y;
      longint            sum_z;
      longint            mag;
      block_stats_result want;
      sum_m = 0;
      sum_x = 0;
      sum_y = 0;
      sum_z = 0;
      if (mode == MODE_NORM) begin
         if (block_pos == 0) begin
            foreach (mag_ring[i]) sum_m += mag_ring[i];
            avg_mag = sum_m >>> DEPTH_LOG2;
         end
         mag = floor_root(longint'(x) * x + longint'(y) * y + longint'(z) * z) + norm_offset;
         if (mag < lowest) lowest = mag;
         if (mag > highest) highest = mag;
         mag_ring[block_pos] = mag;
      end else begin
         // The latch sees the rings as they stand before this sample is stored.
         if (block_pos == 0) begin
            foreach (x_ring[i]) begin
               sum_x += x_ring[i];
               sum_y += y_ring[i];
               sum_z += z_ring[i];
            end
            avg_x = sum_x >>> DEPTH_LOG2;
            avg_y = sum_y >>> DEPTH_LOG2;
            avg_z = sum_z >>> DEPTH_LOG2;
         end
         x_ring[block_pos] = x;
         y_ring[block_pos] = y;
         z_ring[block_pos] = z;
      end
      block_pos = (block_pos + 1) % DEPTH;
      want.avg_norm = avg_mag[NORM_W-1:0];
      want.min_norm = lowest[NORM_W-1:0];
      want.max_norm = highest[NORM_W-1:0];
      want.avg_x    = avg_x[SAMPLE_W-1:0];
      want.avg_y    = avg_y[SAMPLE_W-1:0];
      want.avg_z    = avg_z[SAMPLE_W-1:0];
      want.position = block_pos[POS_OUT_W-1:0];
      due_results.push_back(want);
   endfunction

   task report(string what);
      $display("ERROR at %0t: %s", $realtime, what);
      errors++;
   endtask

   task compare_field(string name, logic [NORM_W-1:0] got, logic [NORM_W-1:0] want);
      if (got !== want) report($sformatf("%s is %h, expected %h", name, got, want));
   endtask

   task check_result(block_stats_result got);
      block_stats_result want;
      if (due_results.size() == 0) begin
         report($sformatf("result transaction with nothing outstanding, position %0d",
                          got.position));
         return;
      end
      want = due_results.pop_front();
      compare_field("avg_norm", got.avg_norm, want.avg_norm);
      compare_field("min_norm", got.min_norm, want.min_norm);
      compare_field("max_norm", got.max_norm, want.max_norm);
      compare_field("avg_x", got.avg_x, want.avg_x);
      compare_field("avg_y", got.avg_y, want.avg_y);
      compare_field("avg_z", got.avg_z, want.avg_z);
      compare_field("position", got.position, want.position);
   endtask
endclass

module vector_norm_block_statistics_core_tb;

   localparam int RANDOM_ITEMS  = 1930;
   localparam int MAX_GAP       = 18;
   localparam int LONG_HOLD     = 400;
   localparam int PRESSURE_RUN  = 2;
   localparam int DRAIN_CYCLES  = 40;
   localparam int IDLE_LIMIT    = 3000;

   localparam logic signed [SAMPLE_W-1:0] AXIS_LOW  = 16'sh8000;
   localparam logic signed [SAMPLE_W-1:0] AXIS_HIGH = 16'sh7FFF;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   vnbs_req_if req_ch ();
   vnbs_rsp_if rsp_ch ();

   block_stats_tracker stats;

   int sender_calm   = 0;
   int receiver_calm = 0;
   int hold_cycles   = 0;
   int idle_cycles   = 0;
   bit sender_eager  = 1'b0;

   vector_norm_block_statistics_core uut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial clock = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly random waits, broken by runs of back-to-back transactions.
   function automatic int next_gap(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, MAX_GAP);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_axis();
      case ($urandom_range(0, 7))
         0:       return AXIS_LOW;
         1:       return AXIS_HIGH;
         2:       return '0;
         3:       return '1;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] x,
                              input logic signed [SAMPLE_W-1:0] y,
                              input logic signed [SAMPLE_W-1:0] z);
      int gap;
      gap = sender_eager ? 0 : next_gap(sender_calm);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.sample_x <= x;
      req_ch.sample_y <= y;
      req_ch.sample_z <= z;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      stats.note_sample(x, y, z);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (stats.due_results.size() != 0) @(posedge clock);
   endtask

   // Writes one register, then reads it straight back.
   task automatic write_register(input reg_index_type index,
                                 input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] mask;
      mask = (index == REG_MODE) ? CSR_DATA_W'(1) : CSR_DATA_W'((1 << OFFSET_W) - 1);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      stats.set_register(index, value);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if ((prdata & mask) !== (value & mask))
         stats.report($sformatf("register %s reads %h, expected %h", index.name(),
                                prdata & mask, value & mask));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin : result_sink
      int                off;
      block_stats_result got;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         off = next_gap(receiver_calm);
         if (hold_cycles > 0) begin
            off += hold_cycles;
            hold_cycles = 0;
         end
         if (off > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (off) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready));
         got.avg_norm = rsp_ch.avg_norm;
         got.min_norm = rsp_ch.min_norm;
         got.max_norm = rsp_ch.max_norm;
         got.avg_x    = rsp_ch.avg_x;
         got.avg_y    = rsp_ch.avg_y;
         got.avg_z    = rsp_ch.avg_z;
         got.position = rsp_ch.position;
         stats.check_result(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int                         count;
      int                         sent;
      int                         phase;
      logic signed [OFFSET_W-1:0] offset;
      stats           = new();
      reset           <= 1'b1;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      req_ch.valid    <= 1'b0;
      req_ch.sample_x <= '0;
      req_ch.sample_y <= '0;
      req_ch.sample_z <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Axis samples come first so that min and max still show their reset values.
      write_register(REG_MODE, CSR_DATA_W'(MODE_AXIS));
      send_sample(AXIS_LOW, AXIS_LOW, AXIS_LOW);
      send_sample(AXIS_HIGH, AXIS_HIGH, AXIS_HIGH);
      send_sample(0, 0, 0);
      send_sample(-1, 1, AXIS_LOW);
      send_sample(AXIS_HIGH, AXIS_LOW, -1);
      drain();
      write_register(REG_MODE, CSR_DATA_W'(MODE_NORM));
      write_register(REG_OFFSET, CSR_DATA_W'(0));
      send_sample(0, 0, 0);
      send_sample(AXIS_LOW, AXIS_LOW, AXIS_LOW);
      send_sample(3, 4, 12);
      send_sample(AXIS_HIGH, 0, AXIS_LOW);
      send_sample(-1, -1, -1);
      drain();
      write_register(REG_OFFSET, CSR_DATA_W'(65535));
      send_sample(AXIS_LOW, AXIS_LOW, AXIS_LOW);
      send_sample(0, 0, 0);
      send_sample(AXIS_HIGH, AXIS_HIGH, AXIS_HIGH);
      drain();
      write_register(REG_OFFSET, CSR_DATA_W'(-65536));
      send_sample(0, 0, 0);
      send_sample(0, AXIS_LOW, 0);
      send_sample(1, 0, 0);
      send_sample(-5, 3, -2);
      // Switching mode inside a block: the position keeps counting for both rings.
      drain();
      write_register(REG_MODE, CSR_DATA_W'(MODE_AXIS));
      send_sample(AXIS_LOW, AXIS_HIGH, -1);
      send_sample(7, -7, 0);
      drain();
      write_register(REG_MODE, CSR_DATA_W'(MODE_NORM));
      send_sample(100, -200, 300);

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         drain();
         write_register(REG_MODE, CSR_DATA_W'($urandom_range(0, 1)));
         case ($urandom_range(0, 4))
            0:       offset = 17'sh0FFFF;
            1:       offset = 17'sh10000;
            2:       offset = '0;
            default: offset = OFFSET_W'($urandom);
         endcase
         write_register(REG_OFFSET, CSR_DATA_W'(offset));
         count = $urandom_range(20, 160);
         if (phase == PRESSURE_RUN) begin
            // The sink goes quiet for a long stretch while samples keep coming.
            count        = 120;
            sender_eager = 1'b1;
            hold_cycles  = LONG_HOLD;
         end
         repeat (count) send_sample(random_axis(), random_axis(), random_axis());
         sender_eager = 1'b0;
         sent += count;
         phase++;
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (stats.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
